### hw/rtl/mdfe_pkg.sv
// ============================================================================
// mdfe_pkg - shared types and constants of the marker-delimited deframer
// Result beat layout, configuration register indexes and queue sizing.
// ============================================================================
package mdfe_pkg;

  // Default sizing handed to the top-level parameters
  localparam int BUF_LEN_DEF    = 32;
  localparam int MARKER_MAX_DEF = 4;

  // Result queue between the scan front and the output side
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Configuration port
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_START_MARKER = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_START_LENGTH = 8'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_END_MARKER   = 8'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_END_LENGTH   = 8'd3;

  localparam logic [31:0] START_MARKER_RST = 32'd60;
  localparam logic [2:0]  START_LENGTH_RST = 3'd1;
  localparam logic [31:0] END_MARKER_RST   = 32'd62;
  localparam logic [2:0]  END_LENGTH_RST   = 3'd1;

  // Marker configuration as seen by the front
  typedef struct packed {
    logic [31:0] start_marker;
    logic [2:0]  start_length;
    logic [31:0] end_marker;
    logic [2:0]  end_length;
  } cfg_t;

  // One result beat
  typedef struct packed {
    logic [7:0] payload_byte;
    logic       last_of_frame;
    logic       empty_frame;
  } res_t;

  // Push request from the front into the result queue
  typedef struct packed {
    logic valid;
    res_t res;
  } push_t;

endpackage

### hw/rtl/mdfe_queue.sv
// ============================================================================
// mdfe_queue - short result queue and output side
// Holds finished result beats and presents the oldest one on the out channel.
// ============================================================================
module mdfe_queue (
  input  logic                       clk,
  input  logic                       rst_n,
  input  mdfe_pkg::push_t            push,
  input  logic                       out_ready,
  output logic                       out_valid,
  output mdfe_pkg::res_t             head,
  output logic [mdfe_pkg::QCNT_W-1:0] count
);

  mdfe_pkg::res_t                    slot_r [mdfe_pkg::QUEUE_DEPTH];
  logic [mdfe_pkg::QPTR_W-1:0]       wp_r, wp_nxt;
  logic [mdfe_pkg::QPTR_W-1:0]       rp_r, rp_nxt;
  logic [mdfe_pkg::QCNT_W-1:0]       cnt_r, cnt_nxt;
  logic                              pop;

  assign out_valid = (cnt_r != '0);
  assign head      = slot_r[rp_r];
  assign count     = cnt_r;
  assign pop       = out_valid && out_ready;

  // Advance pointers and occupancy; the front only pushes when a slot is free
  always_comb begin
    wp_nxt  = push.valid ? wp_r + mdfe_pkg::QPTR_W'(1) : wp_r;
    rp_nxt  = pop ? rp_r + mdfe_pkg::QPTR_W'(1) : rp_r;
    cnt_nxt = cnt_r + mdfe_pkg::QCNT_W'(push.valid) - mdfe_pkg::QCNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // Store pushed beats
  always_ff @(posedge clk) begin
    if (push.valid) begin
      slot_r[wp_r] <= push.res;
    end
  end

endmodule

### hw/rtl/mdfe_front.sv
// ============================================================================
// mdfe_front - byte intake, line store, marker search and payload readout
// Appends each byte to the line store, rescans the store for the first start
// marker and the first end marker after it, and queues the enclosed bytes.
// ============================================================================
module mdfe_front #(
  parameter int BUF_LEN    = mdfe_pkg::BUF_LEN_DEF,
  parameter int MARKER_MAX = mdfe_pkg::MARKER_MAX_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [7:0]                  in_rx_byte,
  input  mdfe_pkg::cfg_t              cfg,
  input  logic [mdfe_pkg::QCNT_W-1:0] q_count,
  output mdfe_pkg::push_t             push
);

  localparam int IW    = $clog2(BUF_LEN);
  localparam int MLIM  = (MARKER_MAX < 4) ? MARKER_MAX : 4;
  localparam int WIN_W = 8 * MLIM;

  typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_EMIT, ST_EMPTY} state_t;

  state_t             state_r, state_nxt;
  logic [IW-1:0]      fill_r, fill_nxt;
  logic [IW-1:0]      rp_r, rp_nxt;
  logic [IW-1:0]      pj_r, pj_nxt;
  logic               dv_r, dv_nxt;
  logic               find_end_r, find_end_nxt;
  logic [2:0]         cnt_r, cnt_nxt;
  logic [WIN_W-1:0]   win_r, win_nxt;
  logic [IW-1:0]      ps_r, ps_nxt;
  logic [IW-1:0]      e_r, e_nxt;

  logic [7:0]         store_mem [BUF_LEN];
  logic [7:0]         rd_data_r;
  logic               rd_en;
  logic               wr_en;
  logic [IW-1:0]      wr_idx;

  logic [2:0]         sl, el, cur_len, cnt_inc;
  logic [31:0]        cur_mk;
  logic [WIN_W-1:0]   win_sh;
  logic               hit;
  logic               last_byte;
  logic [IW-1:0]      e_calc;
  logic               credit;

  // Clamp a marker length to 1..MLIM
  function automatic logic [2:0] eff_len(input logic [2:0] len);
    logic [2:0] r;
    r = len;
    if (len == 3'd0) begin
      r = 3'd1;
    end else if (len > 3'(MLIM)) begin
      r = 3'(MLIM);
    end
    return r;
  endfunction

  // Compare the newest len window bytes against a marker, first byte lowest
  function automatic logic match_f(input logic [WIN_W-1:0] w, input logic [31:0] m,
                                   input logic [2:0] len);
    logic ok;
    int   pos;
    ok = 1'b1;
    for (int k = 0; k < MLIM; k++) begin
      pos = int'(len) - 1 - k;
      if (pos >= 0) begin
        if (w[8*pos +: 8] != m[8*k +: 8]) begin
          ok = 1'b0;
        end
      end
    end
    return ok;
  endfunction

  // Classify the byte returned by the store
  always_comb begin
    sl        = eff_len(cfg.start_length);
    el        = eff_len(cfg.end_length);
    cur_len   = find_end_r ? el : sl;
    cur_mk    = find_end_r ? cfg.end_marker : cfg.start_marker;
    win_sh    = WIN_W'({win_r, rd_data_r});
    cnt_inc   = (cnt_r == 3'(MLIM)) ? cnt_r : cnt_r + 3'd1;
    hit       = dv_r && (cnt_inc >= cur_len) && match_f(win_sh, cur_mk, cur_len);
    last_byte = (pj_r + IW'(1) == fill_r);
    e_calc    = pj_r + IW'(1) - IW'(cur_len);
    credit    = ({1'b0, q_count} + (mdfe_pkg::QCNT_W+1)'(dv_r))
                < (mdfe_pkg::QCNT_W+1)'(mdfe_pkg::QUEUE_DEPTH);
  end

  assign in_ready = (state_r == ST_IDLE);

  // Sequence intake, scan and readout
  always_comb begin
    state_nxt    = state_r;
    fill_nxt     = fill_r;
    rp_nxt       = rp_r;
    pj_nxt       = pj_r;
    dv_nxt       = 1'b0;
    find_end_nxt = find_end_r;
    cnt_nxt      = cnt_r;
    win_nxt      = win_r;
    ps_nxt       = ps_r;
    e_nxt        = e_r;
    rd_en        = 1'b0;
    wr_en        = 1'b0;
    wr_idx       = (fill_r >= IW'(BUF_LEN - 1)) ? '0 : fill_r;
    push         = '0;

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          wr_en        = 1'b1;
          fill_nxt     = wr_idx + IW'(1);
          rp_nxt       = '0;
          find_end_nxt = 1'b0;
          cnt_nxt      = '0;
          state_nxt    = ST_SCAN;
        end
      end

      ST_SCAN: begin
        if (dv_r) begin
          win_nxt = win_sh;
          cnt_nxt = cnt_inc;
        end
        // Issue the next store read
        if (rp_r < fill_r) begin
          rd_en  = 1'b1;
          pj_nxt = rp_r;
          rp_nxt = rp_r + IW'(1);
          dv_nxt = 1'b1;
        end
        if (hit && !find_end_r) begin
          // Start marker found: end search begins at the next byte
          find_end_nxt = 1'b1;
          cnt_nxt      = '0;
          ps_nxt       = pj_r + IW'(1);
          if (last_byte) begin
            state_nxt = ST_IDLE;
          end
        end else if (hit) begin
          // End marker found: drop read in flight, emit payload or empty beat
          e_nxt     = e_calc;
          dv_nxt    = 1'b0;
          rp_nxt    = ps_r;
          fill_nxt  = '0;
          state_nxt = (e_calc == ps_r) ? ST_EMPTY : ST_EMIT;
        end else if (dv_r && last_byte) begin
          state_nxt = ST_IDLE;
        end
      end

      ST_EMIT: begin
        push.valid             = dv_r;
        push.res.payload_byte  = rd_data_r;
        push.res.last_of_frame = (pj_r + IW'(1) == e_r);
        push.res.empty_frame   = 1'b0;
        if (rp_r == e_r) begin
          state_nxt = ST_IDLE;
        end else if (credit) begin
          rd_en  = 1'b1;
          pj_nxt = rp_r;
          rp_nxt = rp_r + IW'(1);
          dv_nxt = 1'b1;
        end
      end

      ST_EMPTY: begin
        if (q_count < mdfe_pkg::QCNT_W'(mdfe_pkg::QUEUE_DEPTH)) begin
          push.valid             = 1'b1;
          push.res.payload_byte  = '0;
          push.res.last_of_frame = 1'b1;
          push.res.empty_frame   = 1'b1;
          state_nxt              = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Hold state and scan registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      fill_r     <= '0;
      rp_r       <= '0;
      dv_r       <= 1'b0;
      find_end_r <= 1'b0;
      cnt_r      <= '0;
      ps_r       <= '0;
      e_r        <= '0;
    end else begin
      state_r    <= state_nxt;
      fill_r     <= fill_nxt;
      rp_r       <= rp_nxt;
      dv_r       <= dv_nxt;
      find_end_r <= find_end_nxt;
      cnt_r      <= cnt_nxt;
      ps_r       <= ps_nxt;
      e_r        <= e_nxt;
    end
  end

  // Registers without reset: read index and scan window
  always_ff @(posedge clk) begin
    pj_r  <= pj_nxt;
    win_r <= win_nxt;
  end

  // Line store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      store_mem[wr_idx] <= in_rx_byte;
    end
    if (rd_en) begin
      rd_data_r <= store_mem[rp_r];
    end
  end

endmodule

### hw/rtl/marker_delimited_frame_extractor_top.sv
// ============================================================================
// marker_delimited_frame_extractor_top - start/end marker deframer
// Bytes enter on the in_ channel, framed payload beats leave on the out_
// channel; marker registers are written through the cfg_ channel.
// ============================================================================
// Usage:
//   in_valid/in_ready move one received byte per beat. out_valid/out_ready
//   move one payload beat (byte, last-of-frame, empty-frame flags).
//   cfg_valid/cfg_ready write register cfg_index with cfg_data; cfg_ready is
//   always high. Write configuration only while no frame is in progress.
// Timing:
//   After a byte is accepted the front rescans the line store, one stored
//   byte per cycle through the store's registered read port. When the end
//   marker is found, payload bytes are read out one per cycle while the
//   result queue has room. Each payload beat passes the store read register
//   and a queue slot before it appears on out_. in_ready is low during the
//   rescan and until every beat of the frame is queued.
// Reset:
//   rst_n clears the line store fill, the result queue and returns the
//   markers to '<' and '>' with length 1. No clearing pass is needed.
// Stall:
//   A four-beat queue parts the front from out_; when it is full the readout
//   pauses and resumes without loss as the receiver takes beats.
// ============================================================================
module marker_delimited_frame_extractor_top #(
  parameter int BUF_LEN    = mdfe_pkg::BUF_LEN_DEF,
  parameter int MARKER_MAX = mdfe_pkg::MARKER_MAX_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [7:0]                      in_rx_byte,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [7:0]                      out_payload_byte,
  output logic                            out_last_of_frame,
  output logic                            out_empty_frame,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [mdfe_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [mdfe_pkg::CFG_DATA_W-1:0] cfg_data
);

  mdfe_pkg::cfg_t                  cfg_r;
  mdfe_pkg::push_t                 push;
  mdfe_pkg::res_t                  head;
  logic [mdfe_pkg::QCNT_W-1:0]     q_count;

  assign cfg_ready = 1'b1;

  // Write marker registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.start_marker <= mdfe_pkg::START_MARKER_RST;
      cfg_r.start_length <= mdfe_pkg::START_LENGTH_RST;
      cfg_r.end_marker   <= mdfe_pkg::END_MARKER_RST;
      cfg_r.end_length   <= mdfe_pkg::END_LENGTH_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        mdfe_pkg::CFG_START_MARKER: cfg_r.start_marker <= cfg_data[31:0];
        mdfe_pkg::CFG_START_LENGTH: cfg_r.start_length <= cfg_data[2:0];
        mdfe_pkg::CFG_END_MARKER:   cfg_r.end_marker   <= cfg_data[31:0];
        mdfe_pkg::CFG_END_LENGTH:   cfg_r.end_length   <= cfg_data[2:0];
        default: begin
        end
      endcase
    end
  end

  mdfe_front #(
    .BUF_LEN    (BUF_LEN),
    .MARKER_MAX (MARKER_MAX)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_rx_byte (in_rx_byte),
    .cfg        (cfg_r),
    .q_count    (q_count),
    .push       (push)
  );

  mdfe_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .head      (head),
    .count     (q_count)
  );

  assign out_payload_byte  = head.payload_byte;
  assign out_last_of_frame = head.last_of_frame;
  assign out_empty_frame   = head.empty_frame;

endmodule
